>>> hw/rtl/lfu_pkg.sv
// ----------------------------------------------------------------------------
// LFU cache package
// Shared sizes, controller states and command/status structs.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int unsigned Entries    = 16;
  localparam int unsigned CountWidth = 16;
  localparam int unsigned CapWidth   = 5;
  localparam logic [CapWidth-1:0] CapReset = 5'd16;

  localparam logic CmdGet = 1'b0;
  localparam logic CmdPut = 1'b1;

  typedef enum logic [5:0] {
    StIdle   = 6'b000001,
    StScan   = 6'b000010,
    StDecide = 6'b000100,
    StEvict  = 6'b001000,
    StApply  = 6'b010000,
    StOut    = 6'b100000
  } state_e;

  typedef struct packed {
    logic start;
    logic scan;
    logic evict;
    logic apply;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic hit;
    logic need_evict;
  } dp_sts_t;

endpackage

>>> hw/rtl/lfu_ctrl.sv
// ----------------------------------------------------------------------------
// LFU cache controller
// Sequences scan, eviction, update and result hand-off.
// ----------------------------------------------------------------------------
module lfu_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output lfu_pkg::dp_cmd_t cmd_o,
  input  lfu_pkg::dp_sts_t sts_i
);

  lfu_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      lfu_pkg::StIdle: begin
        if (in_valid) begin
          cmd_o.start = 1'b1;
          state_d = lfu_pkg::StScan;
        end
      end
      lfu_pkg::StScan: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) state_d = lfu_pkg::StDecide;
      end
      lfu_pkg::StDecide: begin
        if (!sts_i.hit && sts_i.need_evict) state_d = lfu_pkg::StEvict;
        else state_d = lfu_pkg::StApply;
      end
      lfu_pkg::StEvict: begin
        cmd_o.evict = 1'b1;
        state_d = lfu_pkg::StApply;
      end
      lfu_pkg::StApply: begin
        cmd_o.apply = 1'b1;
        state_d = lfu_pkg::StOut;
      end
      lfu_pkg::StOut: begin
        if (!out_stall) state_d = lfu_pkg::StIdle;
      end
      default: state_d = lfu_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lfu_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall  = (state_q != lfu_pkg::StIdle);
  assign out_valid = (state_q == lfu_pkg::StOut);

endmodule

>>> hw/rtl/lfu_dp.sv
// ----------------------------------------------------------------------------
// LFU cache datapath
// Entry registers, serial scan for key match and victim, age/count update.
// ----------------------------------------------------------------------------
module lfu_dp #(
  parameter int unsigned ENTRIES     = lfu_pkg::Entries,
  parameter int unsigned COUNT_WIDTH = lfu_pkg::CountWidth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lfu_pkg::dp_cmd_t              cmd_i,
  output lfu_pkg::dp_sts_t              sts_o,
  input  logic [lfu_pkg::CapWidth-1:0]  cap_i,
  input  logic                          command_i,
  input  logic [31:0]                   key_i,
  input  logic signed [31:0]            value_i,
  output logic                          hit_o,
  output logic signed [31:0]            read_value_o,
  output logic                          evicted_o,
  output logic [31:0]                   evicted_key_o
);

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned NW = $clog2(ENTRIES + 1);
  localparam logic [COUNT_WIDTH-1:0] CntMax = '1;
  localparam logic [NW-1:0] EntN = NW'(ENTRIES);

  logic                   vld_q [ENTRIES];
  logic [31:0]            key_q [ENTRIES];
  logic [31:0]            val_q [ENTRIES];
  logic [COUNT_WIDTH-1:0] cnt_q [ENTRIES];
  logic [IW-1:0]          age_q [ENTRIES];

  logic        cmd_q;
  logic [31:0] ikey_q, ival_q;
  logic [NW-1:0] idx_q, used_q;
  logic        found_q, vic_any_q, free_any_q;
  logic [IW-1:0] found_idx_q, vic_idx_q, free_idx_q;
  logic [COUNT_WIDTH-1:0] vic_cnt_q;
  logic [IW-1:0] vic_age_q;
  logic [IW-1:0] cur;
  logic [NW-1:0] cap_eff;
  logic hit_q, ev_q;
  logic [31:0] rd_q, evk_q;

  assign cur = idx_q[IW-1:0];

  always_comb begin
    if (cap_i == '0) cap_eff = NW'(1);
    else if (int'(cap_i) > int'(ENTRIES)) cap_eff = EntN;
    else cap_eff = NW'(cap_i);
  end

  assign sts_o.scan_done  = (idx_q == EntN);
  assign sts_o.hit        = found_q;
  assign sts_o.need_evict = cmd_q && (used_q >= cap_eff) && vic_any_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) vld_q[i] <= 1'b0;
    end else if (cmd_i.evict) begin
      vld_q[vic_idx_q] <= 1'b0;
    end else if (cmd_i.apply && !found_q && cmd_q && free_any_q) begin
      vld_q[free_idx_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      cmd_q <= command_i;
      ikey_q <= key_i;
      ival_q <= value_i;
      idx_q <= '0;
      used_q <= '0;
      found_q <= 1'b0;
      vic_any_q <= 1'b0;
      free_any_q <= 1'b0;
      hit_q <= 1'b0;
      ev_q <= 1'b0;
      rd_q <= '0;
      evk_q <= '0;
    end
    if (cmd_i.scan && !sts_o.scan_done) begin
      idx_q <= idx_q + NW'(1);
      if (vld_q[cur]) begin
        used_q <= used_q + NW'(1);
        if (!found_q && key_q[cur] == ikey_q) begin
          found_q <= 1'b1;
          found_idx_q <= cur;
        end
        if (!vic_any_q || cnt_q[cur] < vic_cnt_q ||
            (cnt_q[cur] == vic_cnt_q && age_q[cur] > vic_age_q)) begin
          vic_any_q <= 1'b1;
          vic_idx_q <= cur;
          vic_cnt_q <= cnt_q[cur];
          vic_age_q <= age_q[cur];
        end
      end else if (!free_any_q) begin
        free_any_q <= 1'b1;
        free_idx_q <= cur;
      end
    end
    if (cmd_i.evict) begin
      ev_q <= 1'b1;
      evk_q <= key_q[vic_idx_q];
      for (int i = 0; i < ENTRIES; i++)
        if (vld_q[i] && age_q[i] > vic_age_q) age_q[i] <= age_q[i] - IW'(1);
      if (!free_any_q) begin
        free_any_q <= 1'b1;
        free_idx_q <= vic_idx_q;
      end else if (vic_idx_q < free_idx_q) begin
        free_idx_q <= vic_idx_q;
      end
    end
    if (cmd_i.apply) begin
      if (found_q) begin
        hit_q <= 1'b1;
        rd_q <= val_q[found_idx_q];
        for (int i = 0; i < ENTRIES; i++)
          if (vld_q[i] && IW'(i) != found_idx_q && age_q[i] < age_q[found_idx_q])
            age_q[i] <= age_q[i] + IW'(1);
        age_q[found_idx_q] <= '0;
        if (cnt_q[found_idx_q] != CntMax) cnt_q[found_idx_q] <= cnt_q[found_idx_q] + 1'b1;
        if (cmd_q == lfu_pkg::CmdPut) val_q[found_idx_q] <= ival_q;
      end else if (cmd_q == lfu_pkg::CmdPut && free_any_q) begin
        for (int i = 0; i < ENTRIES; i++)
          if (vld_q[i]) age_q[i] <= age_q[i] + IW'(1);
        key_q[free_idx_q] <= ikey_q;
        val_q[free_idx_q] <= ival_q;
        cnt_q[free_idx_q] <= COUNT_WIDTH'(1);
        age_q[free_idx_q] <= '0;
      end
    end
  end

  assign hit_o         = hit_q;
  assign read_value_o  = rd_q;
  assign evicted_o     = ev_q;
  assign evicted_key_o = evk_q;

endmodule

>>> hw/rtl/lfu_cache_with_lru_tiebreak_top.sv
// A word passes through the Scan (serial over the entries), Decide, Evict (on an eviction
// only), Apply and Out states; out_valid is raised in Out. A new word is not taken
// before the last one is through: the next word is taken once the result has been taken.
// Reset (async, low) empties the store and sets capacity to 16.
// ----------------------------------------------------------------------------
// LFU cache top
// Key-value store, least-frequently-used replacement, LRU tie-break.
// ----------------------------------------------------------------------------
module lfu_cache_with_lru_tiebreak_top #(
  parameter int unsigned ENTRIES     = lfu_pkg::Entries,
  parameter int unsigned COUNT_WIDTH = lfu_pkg::CountWidth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [lfu_pkg::CapWidth-1:0] capacity_i,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         command_i,
  input  logic [31:0]                  key_i,
  input  logic signed [31:0]           value_i,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         hit_o,
  output logic signed [31:0]           read_value_o,
  output logic                         evicted_o,
  output logic [31:0]                  evicted_key_o
);

  lfu_pkg::dp_cmd_t cmd;
  lfu_pkg::dp_sts_t sts;
  logic [lfu_pkg::CapWidth-1:0] cap_q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lfu_pkg::CapReset;
    end else if (cfg_valid && cfg_ready) begin
      cap_q <= capacity_i;
    end
  end

  lfu_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_stall, .out_valid, .out_stall,
    .cmd_o(cmd), .sts_i(sts)
  );

  lfu_dp #(.ENTRIES(ENTRIES), .COUNT_WIDTH(COUNT_WIDTH)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .cap_i(cap_q),
    .command_i, .key_i, .value_i, .hit_o, .read_value_o, .evicted_o, .evicted_key_o
  );

endmodule

>>> hw/rtl/lfu_checker.sv
// ----------------------------------------------------------------------------
// LFU cache port checker
// Port-level properties, bound to the top level.
// ----------------------------------------------------------------------------
module lfu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        hit_o,
  input logic        evicted_o,
  input logic [31:0] evicted_key_o,
  input logic [31:0] read_value_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_stall |=> out_valid && $stable(evicted_key_o))
    else $error("result dropped while stalled");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> in_stall)
    else $error("input accepted while result pending");

  a_evict_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && evicted_o |-> !hit_o)
    else $error("eviction on a hit");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !hit_o |-> read_value_o == 32'd0)
    else $error("miss returned nonzero value");

endmodule

bind lfu_cache_with_lru_tiebreak_top lfu_checker u_lfu_checker (
  .clk_i, .rst_ni, .in_valid, .in_stall, .out_valid, .out_stall,
  .hit_o, .evicted_o, .evicted_key_o, .read_value_o
);
